// ===== hdl/lke_pkg.sv =====
package lke_pkg;
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;
    localparam int unsigned FULL_LEVEL = 1000;
    localparam int unsigned IN_BITS  = 88;
    localparam int unsigned OUT_BITS = 16;
endpackage

// ===== hdl/lke_div.sv =====
module lke_div
    import lke_pkg::*;
#(
    parameter int NUM_BITS = 41,
    parameter int DEN_BITS = 24
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [NUM_BITS-1:0] num,
    input  logic        [DEN_BITS-1:0] den,
    output logic                       done,
    output logic signed [NUM_BITS-1:0] quo,
    output logic        [DEN_BITS-1:0] rem
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                neg_reg;
    logic [NUM_BITS-1:0] q_reg;
    logic [DEN_BITS:0]   r_reg;
    logic [DEN_BITS-1:0] d_reg;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;

    // restoring division on magnitudes, one quotient bit per cycle
    assign trial = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_BITS-1];
            q_reg   <= num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
            r_reg   <= '0;
            d_reg   <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_BITS])
            begin
                r_reg <= diff;
                q_reg <= {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign quo = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    // remainder of the magnitudes, valid with done
    assign rem = r_reg[DEN_BITS-1:0];
endmodule

// ===== hdl/looped_keyframe_envelope.sv =====
// Channel   Dir  Fields (low bit up)
// s_axis    in   opcode, slot, entry_index, start_frame, target_level,
//                ramp_length, loop_length, ramp_count
// m_axis    out  tdata: slot_index, level; tlast: last_of_run
// lamps     cfg  lamps_enabled (write enable + data)
// Load, set and restart are taken directly in the idle state. With lamps enabled, a tick
// walks each slot's ramps through the ramp memory, one read (ST_RD, ST_EVAL) per ramp
// plus a serial divide where a ramp is mid-slope; a phase at or beyond a shortened
// loop first costs one more divide.
// Every level waits in the output register until taken; the walk stalls there.
// Reset clears loop lengths, counts and phases; ramp memories stay unwritten.
module looped_keyframe_envelope
    import lke_pkg::*;
#(
    parameter int SLOTS     = 8,
    parameter int RAMPS     = 512,
    parameter int TIME_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // opcode[1:0] slot[4:2] entry_index[13:5] start_frame[29:14]
    // target_level[45:30] ramp_length[61:46] loop_length[77:62] ramp_count[87:78]
    input  logic [IN_BITS-1:0]   s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // slot_index[2:0] level[12:3]
    output logic [OUT_BITS-1:0]  m_axis_tdata,
    output logic                 m_axis_tlast,
    input  logic                 lamps_we,
    input  logic                 lamps_wdata
);
    localparam int SB   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RB   = (RAMPS > 1) ? $clog2(RAMPS) : 1;
    localparam int CB   = $clog2(RAMPS + 1);
    localparam int AB   = SB + RB;
    localparam int DEP  = SLOTS * RAMPS;
    localparam int NB   = TIME_BITS + 18;
    localparam int HB   = 18;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SLOT = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_EVAL = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_MOD  = 3'd6;

    logic [TIME_BITS-1:0] start_mem  [DEP];
    logic [15:0]          target_mem [DEP];
    logic [TIME_BITS-1:0] span_mem   [DEP];
    logic [TIME_BITS-1:0] rd_start;
    logic [15:0]          rd_target;
    logic [TIME_BITS-1:0] rd_span;

    logic [TIME_BITS-1:0] loop_len_reg  [SLOTS];
    logic [CB-1:0]        ramp_count_reg[SLOTS];
    logic [TIME_BITS-1:0] phase_reg     [SLOTS];

    logic                 lamps_reg;
    logic [2:0]           state_reg;
    logic [SB-1:0]        slot_reg;
    logic [CB-1:0]        idx_reg;
    logic                 first_reg;
    logic signed [HB-1:0] held_reg;
    logic signed [HB-1:0] value_reg;
    logic signed [HB-1:0] tgt_reg;
    logic [TIME_BITS-1:0] p_reg;
    logic                 out_valid_reg;
    logic [OUT_BITS-1:0]  out_data_reg;
    logic                 out_last_reg;

    logic [1:0]           op;
    logic [2:0]           in_slot;
    logic [8:0]           in_entry;
    logic [9:0]           in_count;
    logic [TIME_BITS-1:0] cur_loop;
    logic [CB-1:0]        cur_count;
    logic [TIME_BITS-1:0] cur_phase;
    logic                 wrap_needed;
    logic [AB-1:0]        rd_addr;
    logic [CB-1:0]        rd_idx;
    logic                 rd_en;
    logic [TIME_BITS-1:0] step;
    logic [TIME_BITS-1:0] span;
    logic signed [HB-1:0] tgt_s;
    logic signed [NB-1:0] prod;
    logic                 div_start;
    logic                 div_done;
    logic signed [NB-1:0] div_num;
    logic [TIME_BITS-1:0] div_den;
    logic signed [NB-1:0] div_q;
    logic [TIME_BITS-1:0] div_rem;
    logic [TIME_BITS-1:0] next_phase;
    logic [9:0]           clamped;

    assign op       = s_axis_tdata[1:0];
    assign in_slot  = s_axis_tdata[4:2];
    assign in_entry = s_axis_tdata[13:5];
    assign in_count = s_axis_tdata[87:78];
    assign cur_loop  = loop_len_reg[slot_reg];
    assign cur_count = ramp_count_reg[slot_reg];
    assign cur_phase = phase_reg[slot_reg];
    assign wrap_needed = (cur_loop != '0) && (cur_phase >= cur_loop);
    assign s_axis_tready = (state_reg == ST_IDLE);

    // read address: last ramp first (flagged in ST_SLOT), then the ramp walk
    assign rd_idx  = first_reg ? CB'(cur_count - 1'b1) : idx_reg;
    assign rd_addr = AB'(slot_reg) * AB'(RAMPS) + AB'(rd_idx);
    assign rd_en   = (state_reg == ST_RD);

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready && op == OP_LOAD &&
            32'(in_slot) < SLOTS && 32'(in_entry) < RAMPS)
        begin
            start_mem [AB'(in_slot) * AB'(RAMPS) + AB'(in_entry)] <=
                TIME_BITS'(s_axis_tdata[29:14]);
            target_mem[AB'(in_slot) * AB'(RAMPS) + AB'(in_entry)] <= s_axis_tdata[45:30];
            span_mem  [AB'(in_slot) * AB'(RAMPS) + AB'(in_entry)] <=
                TIME_BITS'(s_axis_tdata[61:46]);
        end
        if (rd_en)
        begin
            rd_start  <= start_mem[rd_addr];
            rd_target <= target_mem[rd_addr];
            rd_span   <= span_mem[rd_addr];
        end
    end

    assign step  = p_reg - rd_start;
    assign span  = (rd_span == '0) ? TIME_BITS'(1) : rd_span;
    assign tgt_s = HB'($signed(rd_target));
    assign prod  = NB'(tgt_s - held_reg) * $signed({1'b0, step});
    assign div_start = ((state_reg == ST_SLOT) && wrap_needed) ||
                       ((state_reg == ST_EVAL) && !first_reg && !(rd_start > p_reg) &&
                        !(step >= span) && (idx_reg < cur_count));
    // the divider wraps an out-of-loop phase in ST_SLOT, else interpolates
    assign div_num = (state_reg == ST_SLOT) ? $signed(NB'(cur_phase)) : prod;
    assign div_den = (state_reg == ST_SLOT) ? cur_loop : span;

    lke_div #(.NUM_BITS(NB), .DEN_BITS(TIME_BITS)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q),
        .rem   (div_rem)
    );

    // phase is already below the loop here; wrap at the loop end
    always_comb
    begin
        if (cur_loop == '0)
            next_phase = cur_phase;
        else if (cur_phase + 1'b1 == cur_loop)
            next_phase = '0;
        else
            next_phase = cur_phase + 1'b1;
    end

    always_comb
    begin
        if (value_reg < 0)
            clamped = '0;
        else if (value_reg > HB'(FULL_LEVEL))
            clamped = 10'(FULL_LEVEL);
        else
            clamped = value_reg[9:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamps_reg     <= 1'b0;
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            idx_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                loop_len_reg[i]   <= '0;
                ramp_count_reg[i] <= '0;
                phase_reg[i]      <= '0;
            end
        end
        else
        begin
            if (lamps_we)
                lamps_reg <= lamps_wdata;
            if (m_axis_tvalid && m_axis_tready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        case (op)
                            OP_SET:
                            begin
                                if (32'(in_slot) < SLOTS)
                                begin
                                    loop_len_reg[SB'(in_slot)] <=
                                        TIME_BITS'(s_axis_tdata[77:62]);
                                    ramp_count_reg[SB'(in_slot)] <=
                                        (32'(in_count) > RAMPS) ? CB'(RAMPS) : CB'(in_count);
                                end
                            end
                            OP_RESTART:
                            begin
                                for (int i = 0; i < SLOTS; i++)
                                    phase_reg[i] <= '0;
                            end
                            OP_TICK:
                            begin
                                if (lamps_reg)
                                begin
                                    slot_reg  <= '0;
                                    state_reg <= ST_SLOT;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SLOT:
                begin
                    if (wrap_needed)
                        state_reg <= ST_MOD;
                    else
                    begin
                        phase_reg[slot_reg] <= next_phase;
                        p_reg     <= next_phase;
                        value_reg <= HB'(FULL_LEVEL);
                        idx_reg   <= '0;
                        if (cur_loop == '0 || cur_count == '0)
                            state_reg <= ST_OUT;
                        else
                        begin
                            first_reg <= 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_MOD:
                begin
                    if (div_done)
                    begin
                        phase_reg[slot_reg] <= div_rem;
                        state_reg <= ST_SLOT;
                    end
                end
                ST_RD:
                    state_reg <= ST_EVAL;
                ST_EVAL:
                begin
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        held_reg  <= tgt_s;
                        value_reg <= tgt_s;
                        state_reg <= ST_RD;
                    end
                    else if (idx_reg >= cur_count || rd_start > p_reg)
                        state_reg <= ST_OUT;
                    else if (step >= span)
                    begin
                        value_reg <= tgt_s;
                        held_reg  <= tgt_s;
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= (idx_reg + 1'b1 >= cur_count) ? ST_OUT : ST_RD;
                    end
                    else
                    begin
                        tgt_reg   <= tgt_s;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        value_reg <= held_reg + HB'(div_q);
                        held_reg  <= tgt_reg;
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= (idx_reg + 1'b1 >= cur_count) ? ST_OUT : ST_RD;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= OUT_BITS'({clamped, 3'(slot_reg)});
                        out_last_reg  <= (32'(slot_reg) == SLOTS - 1);
                        if (32'(slot_reg) == SLOTS - 1)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            slot_reg  <= slot_reg + 1'b1;
                            state_reg <= ST_SLOT;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[12:3] <= 10'(FULL_LEVEL))
        else $error("level above full scale");
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV || state_reg == ST_MOD)
        else $error("divider finished outside divide state");
`endif
endmodule
